### rtl/lzwsd_pkg.sv
`default_nettype none
package lzwsd_pkg;

  localparam int unsigned DictEntries = 512;
  localparam int unsigned StoreDepth  = 512;
  localparam int unsigned AddrW       = 9;
  localparam int unsigned PosW        = 10;
  localparam int unsigned CodeW       = 10;
  localparam int unsigned WordBytes   = 8;

  localparam logic [CodeW-1:0] LastCode   = CodeW'(DictEntries - 1);
  localparam logic [CodeW-1:0] LiteralTop = CodeW'(255);
  localparam logic [PosW-1:0]  StackEnd   = PosW'(StoreDepth);
  localparam logic [3:0]       LitWidth   = 4'd8;
  localparam logic [3:0]       FirstWidth = 4'd9;

  typedef enum logic [1:0] {
    CLS_KNOWN,
    CLS_KWKWK,
    CLS_BAD
  } lzwsd_cls_e;

  typedef struct packed {
    logic shift_in;
    logic consume;
    logic literal;
    logic fail;
    logic add;
    logic add_kw;
    logic rd_cur;
    logic rd_next;
    logic push_suf;
    logic push_lit;
    logic finish;
    logic emit_run;
    logic out_load;
  } lzwsd_cmd_t;

  typedef struct packed {
    logic       halted;
    logic       lit_mode;
    logic       enough;
    lzwsd_cls_e cls;
    logic       known_q;
    logic       cur_lit;
    logic       next_lit;
    logic       pos_one;
    logic       word_done;
    logic       run_end;
    logic       out_free;
  } lzwsd_sts_t;

endpackage
`default_nettype wire

### rtl/lzwsd_ram.sv
`default_nettype none
module lzwsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/lzwsd_datapath.sv
`default_nettype none
module lzwsd_datapath
  import lzwsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lzwsd_cmd_t  cmd_i,
  output lzwsd_sts_t       sts_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             last_of_run_o,
  output logic             status_o
);

  logic [15:0]      holder_q, holder_d;
  logic [4:0]       count_q, count_d;
  logic [CodeW-1:0] highest_q, highest_d;
  logic [3:0]       cw_q, cw_d;
  logic [AddrW-1:0] prev_code_q, prev_code_d;
  logic [7:0]       prev_first_q, prev_first_d;
  logic             want_lit_q, want_lit_d;
  logic             halted_q, halted_d;
  logic [CodeW-1:0] code_q, code_d;
  lzwsd_cls_e       cls_q, cls_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       first_q, first_d;
  logic [PosW-1:0]  idx_q, idx_d;
  logic [3:0]       iss_q, iss_d;
  logic [3:0]       wk_cnt_q, wk_cnt_d;
  logic [63:0]      word_q, word_d;
  logic             err_q, err_d;
  logic             rv_q, rv_d;
  logic             ovalid_q, ovalid_d;
  logic [63:0]      obytes_q;
  logic [3:0]       ocount_q;
  logic             olast_q, ostatus_q;

  logic [3:0]       cw_eff, need;
  logic [4:0]       sh;
  logic [15:0]      shifted;
  logic [CodeW-1:0] code_c, mask, next_free;
  lzwsd_cls_e       cls_c;
  logic [AddrW-1:0] pre_rd, dict_raddr;
  logic [7:0]       suf_rd, stk_rd, stk_wdata;
  logic             dict_we, dict_re, stk_we, issue;
  logic [7:0]       add_suf;
  logic [PosW-1:0]  pos_m1;
  logic [10:0]      hc_p1, pow;

  assign cw_eff    = (cw_q < LitWidth || cw_q > 4'd10) ? FirstWidth : cw_q;
  assign need      = want_lit_q ? LitWidth : cw_eff;
  assign sh        = count_q - {1'b0, need};
  assign shifted   = holder_q >> sh;
  assign mask      = CodeW'((11'd1 << need) - 11'd1);
  assign code_c    = shifted[CodeW-1:0] & mask;
  assign next_free = highest_q + CodeW'(1);
  assign cls_c     = (code_c <= highest_q) ? CLS_KNOWN :
                     (code_c == next_free && code_c <= LastCode) ? CLS_KWKWK : CLS_BAD;

  assign add_suf    = cmd_i.add_kw ? prev_first_q : first_q;
  assign dict_we    = cmd_i.add && (next_free <= LastCode);
  assign dict_re    = cmd_i.rd_cur || cmd_i.rd_next;
  assign dict_raddr = cmd_i.rd_next ? pre_rd : cur_q;
  assign pos_m1     = pos_q - PosW'(1);
  assign stk_we     = cmd_i.push_suf || cmd_i.push_lit;
  assign stk_wdata  = cmd_i.push_suf ? suf_rd : cur_q[7:0];
  assign issue      = cmd_i.emit_run && (idx_q < StackEnd) && (iss_q < 4'(WordBytes));
  assign hc_p1      = {1'b0, highest_q} + 11'd1;
  assign pow        = 11'd1 << cw_q;

  lzwsd_ram #(.Width(AddrW), .Depth(StoreDepth)) u_prefix (
    .clk_i, .we_i(dict_we), .waddr_i(next_free[AddrW-1:0]), .wdata_i(prev_code_q),
    .re_i(dict_re), .raddr_i(dict_raddr), .rdata_o(pre_rd)
  );

  lzwsd_ram #(.Width(8), .Depth(StoreDepth)) u_suffix (
    .clk_i, .we_i(dict_we), .waddr_i(next_free[AddrW-1:0]), .wdata_i(add_suf),
    .re_i(dict_re), .raddr_i(dict_raddr), .rdata_o(suf_rd)
  );

  lzwsd_ram #(.Width(8), .Depth(StoreDepth)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(pos_m1[AddrW-1:0]), .wdata_i(stk_wdata),
    .re_i(issue), .raddr_i(idx_q[AddrW-1:0]), .rdata_o(stk_rd)
  );

  always_comb begin
    holder_d     = holder_q;
    count_d      = count_q;
    highest_d    = highest_q;
    cw_d         = cw_q;
    prev_code_d  = prev_code_q;
    prev_first_d = prev_first_q;
    want_lit_d   = want_lit_q;
    halted_d     = halted_q;
    code_d       = code_q;
    cls_d        = cls_q;
    cur_d        = cur_q;
    pos_d        = pos_q;
    first_d      = first_q;
    idx_d        = idx_q;
    iss_d        = iss_q;
    wk_cnt_d     = wk_cnt_q;
    word_d       = word_q;
    err_d        = err_q;
    rv_d         = issue;
    ovalid_d     = ovalid_q && !out_ready_i;

    if (cmd_i.shift_in) begin
      holder_d = {holder_q[7:0], in_byte_i};
      count_d  = (count_q > 5'd8) ? 5'd16 : count_q + 5'd8;
    end
    if (cmd_i.consume) begin
      count_d = sh;
      code_d  = code_c;
      cls_d   = cls_c;
      cur_d   = code_c[AddrW-1:0];
      pos_d   = StackEnd;
      if (!want_lit_q) begin
        cw_d = cw_eff;
      end
    end
    if (cmd_i.literal) begin
      want_lit_d   = 1'b0;
      cw_d         = FirstWidth;
      prev_code_d  = {1'b0, code_c[7:0]};
      prev_first_d = code_c[7:0];
      word_d       = {code_c[7:0], 56'd0};
      wk_cnt_d     = 4'd1;
      err_d        = 1'b0;
      idx_d        = StackEnd;
    end
    if (cmd_i.fail) begin
      halted_d = 1'b1;
      word_d   = 64'd0;
      wk_cnt_d = 4'd0;
      err_d    = 1'b1;
      idx_d    = StackEnd;
    end
    if (dict_we) begin
      highest_d = next_free;
    end
    if (cmd_i.push_suf) begin
      pos_d   = pos_m1;
      first_d = suf_rd;
      cur_d   = pre_rd;
    end
    if (cmd_i.push_lit) begin
      pos_d   = pos_m1;
      first_d = cur_q[7:0];
    end
    if (cmd_i.finish) begin
      prev_first_d = first_q;
      prev_code_d  = code_q[AddrW-1:0];
      idx_d        = pos_q;
      iss_d        = 4'd0;
      wk_cnt_d     = 4'd0;
      word_d       = 64'd0;
      err_d        = 1'b0;
      if (highest_q >= LastCode) begin
        highest_d  = LiteralTop;
        cw_d       = LitWidth;
        want_lit_d = 1'b1;
      end else if (hc_p1 == pow) begin
        cw_d = cw_q + 4'd1;
      end
    end
    if (issue) begin
      idx_d = idx_q + PosW'(1);
      iss_d = iss_q + 4'd1;
    end
    if (cmd_i.emit_run && rv_q) begin
      for (int j = 0; j < WordBytes; j++) begin
        if (wk_cnt_q == 4'(j)) begin
          word_d[63-8*j -: 8] = stk_rd;
        end
      end
      wk_cnt_d = wk_cnt_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      ovalid_d = 1'b1;
      iss_d    = 4'd0;
      wk_cnt_d = 4'd0;
      word_d   = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holder_q     <= '0;
      count_q      <= '0;
      highest_q    <= LiteralTop;
      cw_q         <= LitWidth;
      prev_code_q  <= '0;
      prev_first_q <= '0;
      want_lit_q   <= 1'b1;
      halted_q     <= 1'b0;
      cls_q        <= CLS_KNOWN;
      pos_q        <= StackEnd;
      idx_q        <= StackEnd;
      iss_q        <= '0;
      wk_cnt_q     <= '0;
      err_q        <= 1'b0;
      rv_q         <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      holder_q     <= holder_d;
      count_q      <= count_d;
      highest_q    <= highest_d;
      cw_q         <= cw_d;
      prev_code_q  <= prev_code_d;
      prev_first_q <= prev_first_d;
      want_lit_q   <= want_lit_d;
      halted_q     <= halted_d;
      cls_q        <= cls_d;
      pos_q        <= pos_d;
      idx_q        <= idx_d;
      iss_q        <= iss_d;
      wk_cnt_q     <= wk_cnt_d;
      err_q        <= err_d;
      rv_q         <= rv_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    cur_q   <= cur_d;
    first_q <= first_d;
    word_q  <= word_d;
    if (cmd_i.out_load) begin
      obytes_q  <= word_q;
      ocount_q  <= wk_cnt_q;
      olast_q   <= (idx_q == StackEnd);
      ostatus_q <= err_q;
    end
  end

  assign sts_o.halted    = halted_q;
  assign sts_o.lit_mode  = want_lit_q;
  assign sts_o.enough    = ({1'b0, need} <= count_q);
  assign sts_o.cls       = cls_c;
  assign sts_o.known_q   = (cls_q == CLS_KNOWN);
  assign sts_o.cur_lit   = !cur_q[AddrW-1];
  assign sts_o.next_lit  = !pre_rd[AddrW-1];
  assign sts_o.pos_one   = (pos_q == PosW'(1));
  assign sts_o.word_done = !issue && !rv_q;
  assign sts_o.run_end   = (idx_q == StackEnd);
  assign sts_o.out_free  = !ovalid_q || out_ready_i;

  assign out_valid_o   = ovalid_q;
  assign out_bytes_o   = obytes_q;
  assign byte_count_o  = ocount_q;
  assign last_of_run_o = olast_q;
  assign status_o      = ostatus_q;

endmodule
`default_nettype wire

### rtl/lzwsd_ctrl.sv
`default_nettype none
module lzwsd_ctrl
  import lzwsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire lzwsd_sts_t sts_i,
  output lzwsd_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK_START,
    ST_WALK,
    ST_PUSH_LIT,
    ST_ADD,
    ST_FINISH,
    ST_EMIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.halted) begin
          cmd_o.shift_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts_i.enough) begin
          state_d = ST_IDLE;
        end else if (sts_i.lit_mode) begin
          cmd_o.consume = 1'b1;
          cmd_o.literal = 1'b1;
          state_d       = ST_OUT;
        end else if (sts_i.cls == CLS_BAD) begin
          cmd_o.consume = 1'b1;
          cmd_o.fail    = 1'b1;
          state_d       = ST_OUT;
        end else begin
          cmd_o.consume = 1'b1;
          cmd_o.add     = (sts_i.cls == CLS_KWKWK);
          cmd_o.add_kw  = 1'b1;
          state_d       = ST_WALK_START;
        end
      end
      ST_WALK_START: begin
        if (sts_i.cur_lit) begin
          state_d = ST_PUSH_LIT;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.push_suf = 1'b1;
        if (sts_i.pos_one) begin
          state_d = ST_ADD;
        end else if (sts_i.next_lit) begin
          state_d = ST_PUSH_LIT;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      ST_PUSH_LIT: begin
        cmd_o.push_lit = 1'b1;
        state_d        = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = sts_i.known_q;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_run = 1'b1;
        if (sts_i.word_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.run_end ? ST_IDLE : ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/lzw_stream_decoder_core.sv
`default_nettype none
// LZW decoder for an MSB-first packed code stream of 9-bit codes; an 8-bit literal leads the
// stream and follows each dictionary reset. The dictionary walk reads one prefix entry per
// cycle, and each full output word of eight bytes is read from the string stack through its
// single read port. A new input transaction is taken only after the last word of the
// previous code is in the output register, which holds it until the downstream side takes
// it. An invalid code gives one word with status set and halts the decoder until reset.
module lzw_stream_decoder_core
  import lzwsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             last_of_run_o,
  output logic             status_o
);

  lzwsd_cmd_t cmd;
  lzwsd_sts_t sts;

  lzwsd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  lzwsd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_byte_i, .out_ready_i,
    .out_valid_o, .out_bytes_o, .byte_count_o, .last_of_run_o, .status_o
  );

endmodule
`default_nettype wire

### tb/sv/lzw_stream_decoder_core_tb.sv
module lzw_stream_decoder_core_tb;
  import lzwsd_pkg::*;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic        status;
  } lzw_word_t;

  class lzw_scoreboard;
    bit [8:0] prefix_tab[512];
    bit [7:0] suffix_tab[512];
    bit [7:0] run_stack[512];
    bit [15:0] holder;
    int unsigned nbits, top, width, prev, prev_first;
    bit lit_next, dead;
    lzw_word_t pending[$];
    int mismatches;

    function new();
      holder = 0;
      nbits = 0;
      top = 255;
      width = 8;
      prev = 0;
      prev_first = 0;
      lit_next = 1;
      dead = 0;
      mismatches = 0;
      foreach (prefix_tab[i]) begin
        prefix_tab[i] = 0;
        suffix_tab[i] = 0;
        run_stack[i] = 0;
      end
    endfunction

    function int unsigned unwind(int unsigned c);
      int unsigned pos;
      pos = 512;
      c = c & 511;
      while (pos > 0) begin
        pos--;
        if (c < 256) begin
          run_stack[pos] = c[7:0];
          break;
        end
        run_stack[pos] = suffix_tab[c];
        c = prefix_tab[c];
      end
      return pos;
    endfunction

    function void queue_run(int unsigned start);
      int unsigned i, k;
      lzw_word_t w;
      i = start;
      while (i < 512) begin
        w = '0;
        k = 0;
        while (k < 8 && i < 512) begin
          w.bytes[63 - 8 * k -: 8] = run_stack[i];
          k++;
          i++;
        end
        w.cnt = k[3:0];
        w.last = (i >= 512);
        pending.push_back(w);
      end
    endfunction

    function void grow(int unsigned p, int unsigned s);
      if (top + 1 <= DictEntries - 1) begin
        prefix_tab[top + 1] = p[8:0];
        suffix_tab[top + 1] = s[7:0];
        top = top + 1;
      end
    endfunction

    function void note_input(bit [7:0] b);
      int unsigned c, start;
      lzw_word_t w;
      if (dead) return;
      holder = {holder[7:0], b};
      nbits += 8;
      if (nbits > 16) nbits = 16;
      if (lit_next) begin
        nbits -= 8;
        c = (holder >> nbits) & 8'hFF;
        lit_next = 0;
        width = 9;
        prev = c;
        prev_first = c;
        w = '0;
        w.bytes[63:56] = c[7:0];
        w.cnt = 1;
        w.last = 1;
        pending.push_back(w);
        return;
      end
      if (width < 8 || width > 10) width = 9;
      if (nbits < width) return;
      nbits -= width;
      c = (holder >> nbits) & ((1 << width) - 1);
      if (c <= top) begin
        start = unwind(c);
        queue_run(start);
        prev_first = run_stack[start];
        grow(prev, prev_first);
      end else if (c == top + 1 && c < DictEntries) begin
        grow(prev, prev_first);
        start = unwind(c);
        queue_run(start);
        prev_first = run_stack[start];
      end else begin
        dead = 1;
        w = '0;
        w.last = 1;
        w.status = 1;
        pending.push_back(w);
        return;
      end
      prev = c & 511;
      if (top + 1 == (1 << width)) width++;
      if (top >= DictEntries - 1) begin
        top = 255;
        width = 8;
        lit_next = 1;
      end
    endfunction

    function void check_result(lzw_word_t got);
      lzw_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: bytes=%h count=%0d last=%b status=%b",
                   got.bytes, got.cnt, got.last, got.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp bytes=%h count=%0d last=%b status=%b, got bytes=%h count=%0d last=%b status=%b",
                   want.bytes, want.cnt, want.last, want.status,
                   got.bytes, got.cnt, got.last, got.status);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [63:0] out_bytes_o;
  logic [3:0]  byte_count_o;
  logic        last_of_run_o;
  logic        status_o;

  lzw_stream_decoder_core uut (.*);

  lzw_scoreboard sb = new();
  bit stream_bits[$];
  bit [7:0] stream_bytes[$];
  int unsigned gen_top = 255, gen_width = 8;
  bit gen_lit = 1;
  bit tail_mode = 0;
  int unsigned sink_stall = 0;
  int unsigned idle_cycles = 0;

  initial forever #1 clk_i = ~clk_i;

  function automatic void pack_bits(int unsigned v, int unsigned w);
    for (int i = w - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endfunction

  function automatic void gen_code(int unsigned c);
    if (gen_lit) begin
      pack_bits(c & 8'hFF, 8);
      gen_lit = 0;
      gen_width = 9;
      return;
    end
    pack_bits(c, gen_width);
    if (gen_top + 1 <= DictEntries - 1) gen_top++;
    if (gen_top + 1 == (1 << gen_width)) gen_width++;
    if (gen_top >= DictEntries - 1) begin
      gen_top = 255;
      gen_width = 8;
      gen_lit = 1;
    end
  endfunction

  function automatic int unsigned pick_code();
    int unsigned r;
    if (gen_lit) return $urandom_range(0, 255);
    r = $urandom_range(0, 3);
    if (r == 0) return gen_top + 1;
    if (r == 1) return gen_top;
    return $urandom_range(0, gen_top + 1);
  endfunction

  always @(posedge clk_i) begin
    lzw_word_t got;
    if (in_valid_i && in_ready_o) sb.note_input(in_byte_i);
    if (out_valid_o && out_ready_i) begin
      got = {out_bytes_o, byte_count_o, last_of_run_o, status_o};
      sb.check_result(got);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("lzw_stream_decoder_core_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (tail_mode) begin
      out_ready_i <= 1;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready_i <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 4);
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  task automatic send_byte(bit [7:0] b, bit may_idle);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    bit [7:0] b;
    int n;

    // Directed opening: literal 255, the not-yet-defined code, extremes.
    gen_code(255);
    gen_code(256);
    gen_code(0);
    gen_code(257);
    gen_code(255);
    gen_code(gen_top + 1);
    gen_code(gen_top);
    while (stream_bits.size() < 8 * 430) gen_code(pick_code());
    while (gen_lit || gen_top + 2 >= (1 << gen_width)) gen_code(pick_code());
    // Invalid code halts the decoder.
    pack_bits($urandom_range(gen_top + 2, (1 << gen_width) - 1), gen_width);
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(0);
    for (int i = 0; i < stream_bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7 - j] = stream_bits[i + j];
      stream_bytes.push_back(b);
    end
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back($urandom_range(0, 255));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    n = stream_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_valid_i <= 0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if (i == n - 60) tail_mode = 1;
      send_byte(stream_bytes[i], !tail_mode);
    end
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("lzw_stream_decoder_core_tb OK");
    end else begin
      $display("lzw_stream_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/lzwsd_pkg.sv
rtl/lzwsd_ram.sv
rtl/lzwsd_datapath.sv
rtl/lzwsd_ctrl.sv
rtl/lzw_stream_decoder_core.sv
tb/sv/lzw_stream_decoder_core_tb.sv
